@@ hw/rtl/psopt_pkg.sv @@
// Shared types, register codes and arithmetic helpers of the particle swarm optimizer.
package psopt_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_COG_GAIN   = 3'd0,
    REG_SOC_GAIN   = 3'd1,
    REG_START_POS  = 3'd2,
    REG_ACTIVE     = 3'd3,
    REG_STOP_THR   = 3'd4,
    REG_STEP_LIMIT = 3'd5
  } cfg_reg_t;

  // Item kinds carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Register reset values.
  localparam logic [15:0]        RESET_GAIN       = 16'd2048;
  localparam logic signed [31:0] RESET_START      = 32'sd65536;
  localparam logic signed [31:0] RESET_START_COST = -32'sd65536;
  localparam logic [7:0]         RESET_ACTIVE     = 8'd100;
  localparam logic [30:0]        RESET_STOP_THR   = 31'd7;
  localparam logic [7:0]         RESET_STEP_LIMIT = 8'd50;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MS_W_VEL    = 3'd0,
    MS_CR1      = 3'd1,
    MS_G_PB     = 3'd2,
    MS_CR2      = 3'd3,
    MS_G_GB     = 3'd4,
    MS_SQ_START = 3'd5,
    MS_SQ_LOAD  = 3'd6,
    MS_SQ_NP    = 3'd7
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take;
    logic     restart;
    logic     load_wr;
    logic     div_start;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     latch;
    logic     mul_en;
    logic     sq;
    mul_sel_t mul_sel;
    logic     acc_init;
    logic     acc_add;
    logic     cost_a;
    logic     cost_b;
    logic     vel_upd;
    logic     pos_upd;
    logic     pb_upd;
    logic     gb_upd;
    logic     step_inc;
    logic     scan_rd;
    logic     spread;
    logic     spread_clr;
    logic     flags;
    logic     out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_step;
    logic in_idx_zero;
    logic can_update;
    logic div_busy;
    logic cnt_last;
  } dp_status_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/particle_swarm_optimizer_1d_unit.sv @@
// Top level of the one-dimensional particle swarm optimizer.
//
// Minimizes x*x - 3x + 1 over signed Q16.16 particles held in five on-chip memories of
// MAX_PARTICLES entries each. One item is processed at a time and each item returns one
// status transaction. A load computes the cost of the loaded position and writes the
// particle; a load of particle 0 first restarts the run from the start position. A step
// that moves the swarm first forms the inertia weight in the bit-serial divider, then
// passes each active particle through the single shared multiplier (inertia, two gains,
// two pulls and the squared position of the new cost), then runs the position and cost
// spread scan over the memory read port, one particle per cycle. A step after the run
// has finished only scans. The next item is accepted while the previous result still
// waits in the output register. Particles must be loaded before a step reads them;
// their memories are not cleared by reset.
module particle_swarm_optimizer_1d_unit import psopt_pkg::*; #(
  parameter int MAX_PARTICLES = 128
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: particle_index[6:0], init_position[38:7], init_velocity[70:39],
  // rand1[86:71], rand2[102:87], zero fill [103].
  input  logic [103:0] s_axis_tdata,
  // tuser: op (0 load, 1 step).
  input  logic         s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: best_position[31:0], best_cost[63:32], position_spread[94:64],
  // cost_spread[125:95], steps_done[133:126], converged[134], finished[135].
  output logic [135:0] m_axis_tdata,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic signed [31:0] best_position;
  logic signed [31:0] best_cost;
  logic [30:0]        position_spread;
  logic [30:0]        cost_spread;
  logic [7:0]         steps_done;
  logic               converged;
  logic               finished;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  psopt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  psopt_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (s_axis_tuser),
    .in_idx          (s_axis_tdata[6:0]),
    .in_pos          (s_axis_tdata[38:7]),
    .in_vel          (s_axis_tdata[70:39]),
    .in_r1           (s_axis_tdata[86:71]),
    .in_r2           (s_axis_tdata[102:87]),
    .cmd             (cmd),
    .status          (status),
    .best_position   (best_position),
    .best_cost       (best_cost),
    .position_spread (position_spread),
    .cost_spread     (cost_spread),
    .steps_done      (steps_done),
    .converged       (converged),
    .finished        (finished)
  );

  // Result packing.
  assign m_axis_tdata = {finished, converged, steps_done, cost_spread, position_spread,
                         best_cost, best_position};

endmodule

@@ hw/rtl/psopt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psopt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/psopt_div.sv @@
// Restoring divider that forms the inertia weight 65536 / divisor one bit per cycle.
module psopt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [8:0]  divisor,
  output logic [16:0] quotient,
  output logic        busy
);

  localparam logic [4:0] QBITS = 5'd17;

  logic [4:0] left;
  logic [8:0] rem;
  logic [8:0] dvs;
  logic [9:0] rem_sh;
  logic [9:0] rem_sub;

  // The dividend is a single one in its top bit followed by zeros.
  assign rem_sh  = {rem, (left == QBITS)};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign busy    = (left != 5'd0);

  // Bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 5'd0;
    end else if (start) begin
      left <= QBITS;
    end else if (busy) begin
      left <= left - 5'd1;
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 9'd0;
      quotient <= 17'd0;
      dvs      <= divisor;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem      <= rem_sub[8:0];
        quotient <= {quotient[15:0], 1'b1};
      end else begin
        rem      <= rem_sh[8:0];
        quotient <= {quotient[15:0], 1'b0};
      end
    end
  end

endmodule

@@ hw/rtl/psopt_dp.sv @@
// Datapath: configuration, particle memories, shared multiplier, cost and spread logic.
module psopt_dp import psopt_pkg::*; #(
  parameter int MAX_PARTICLES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_op,
  input  logic [6:0]         in_idx,
  input  logic signed [31:0] in_pos,
  input  logic signed [31:0] in_vel,
  input  logic [15:0]        in_r1,
  input  logic [15:0]        in_r2,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic signed [31:0] best_position,
  output logic signed [31:0] best_cost,
  output logic [30:0]        position_spread,
  output logic [30:0]        cost_spread,
  output logic [7:0]         steps_done,
  output logic               converged,
  output logic               finished
);

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  // Configuration registers.
  logic [15:0]        cog_gain;
  logic [15:0]        soc_gain;
  logic signed [31:0] start_pos;
  logic [7:0]         active;
  logic [30:0]        stop_thr;
  logic [7:0]         step_limit;

  // Accepted item.
  logic [6:0]         idx_r;
  logic signed [31:0] ipos_r;
  logic signed [31:0] ivel_r;
  logic [15:0]        r1_r;
  logic [15:0]        r2_r;

  // Swarm state.
  logic signed [31:0] gb_pos;
  logic signed [31:0] gb_cost;
  logic [7:0]         step_cnt;
  logic               run_fin;
  logic               run_conv;

  // Particle work registers.
  logic [IW-1:0]      cnt;
  logic [IW-1:0]      last_idx;
  logic signed [31:0] pos_r;
  logic signed [31:0] vel_r;
  logic signed [31:0] pbp_r;
  logic signed [31:0] pbc_r;
  logic signed [39:0] acc;
  logic signed [31:0] nv;
  logic signed [31:0] np;
  logic signed [65:0] prod;
  logic signed [31:0] cx;
  logic signed [67:0] csum;
  logic signed [31:0] cres;
  logic [16:0]        w_q;
  logic               div_busy;

  // Spread scan.
  logic               scan_v;
  logic               scan_first;
  logic signed [31:0] plo, phi, clo, chi;
  logic [30:0]        pspread_r;
  logic [30:0]        cspread_r;

  // Memory ports.
  logic [IW-1:0]      waddr;
  logic               idx_ok;
  logic               we_main;
  logic               we_pb;
  logic               better;
  logic [31:0]        wpos, wvel, wcost;
  logic [31:0]        rd_pos, rd_vel, rd_cost, rd_pbp, rd_pbc;

  // Multiplier and arithmetic nets.
  logic signed [32:0] ma, mb;
  logic signed [65:0] p_sh16, p_sh12;
  logic signed [67:0] prod_e, cx_e, csum_sh;
  logic signed [32:0] pos_sum;
  logic [32:0]        pd, cd;

  // Effective particle count, clamped to one through the memory depth.
  always_comb begin
    if (active == 8'd0) begin
      last_idx = '0;
    end else if (int'(active) > MAX_PARTICLES) begin
      last_idx = IW'(MAX_PARTICLES - 1);
    end else begin
      last_idx = IW'(active - 8'd1);
    end
  end

  assign idx_ok = (int'(idx_r) < MAX_PARTICLES);

  assign status.in_step     = (in_op == OP_STEP);
  assign status.in_idx_zero = (in_idx == 7'd0);
  assign status.can_update  = !run_fin && (step_cnt < step_limit);
  assign status.div_busy    = div_busy;
  assign status.cnt_last    = (cnt == last_idx);

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cog_gain   <= RESET_GAIN;
      soc_gain   <= RESET_GAIN;
      start_pos  <= RESET_START;
      active     <= RESET_ACTIVE;
      stop_thr   <= RESET_STOP_THR;
      step_limit <= RESET_STEP_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COG_GAIN:   cog_gain   <= cfg_data[15:0];
        REG_SOC_GAIN:   soc_gain   <= cfg_data[15:0];
        REG_START_POS:  start_pos  <= cfg_data;
        REG_ACTIVE:     active     <= cfg_data[7:0];
        REG_STOP_THR:   stop_thr   <= cfg_data[30:0];
        REG_STEP_LIMIT: step_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_r  <= in_idx;
      ipos_r <= in_pos;
      ivel_r <= in_vel;
      r1_r   <= in_r1;
      r2_r   <= in_r2;
    end
  end

  // Particle counter shared by the update loop and the spread scan.
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + IW'(1);
    end
  end

  // Inertia weight divider.
  psopt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  ({1'b0, step_cnt} + 9'd1),
    .quotient (w_q),
    .busy     (div_busy)
  );

  // Shared multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_sel)
      MS_W_VEL: begin
        ma = $signed({16'd0, w_q});
        mb = {vel_r[31], vel_r};
      end
      MS_CR1: begin
        ma = $signed({17'd0, cog_gain});
        mb = $signed({17'd0, r1_r});
      end
      MS_G_PB: begin
        ma = {pbp_r[31], pbp_r} - {pos_r[31], pos_r};
        mb = $signed({17'd0, prod[31:16]});
      end
      MS_CR2: begin
        ma = $signed({17'd0, soc_gain});
        mb = $signed({17'd0, r2_r});
      end
      MS_G_GB: begin
        ma = {gb_pos[31], gb_pos} - {pos_r[31], pos_r};
        mb = $signed({17'd0, prod[31:16]});
      end
      MS_SQ_START: begin
        ma = {start_pos[31], start_pos};
        mb = {start_pos[31], start_pos};
      end
      MS_SQ_LOAD: begin
        ma = {ipos_r[31], ipos_r};
        mb = {ipos_r[31], ipos_r};
      end
      MS_SQ_NP: begin
        ma = {np[31], np};
        mb = {np[31], np};
      end
      default: ;
    endcase
  end

  assign p_sh16  = prod >>> 16;
  assign p_sh12  = prod >>> 12;
  assign prod_e  = {{2{prod[65]}}, prod};
  assign cx_e    = {{36{cx[31]}}, cx};
  assign csum_sh = csum >>> 16;
  assign pos_sum = {pos_r[31], pos_r} + {nv[31], nv};
  assign better  = (cres < pbc_r);

  // Velocity, position and cost pipeline of one particle.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
    if (cmd.sq) begin
      unique case (cmd.mul_sel)
        MS_SQ_START: cx <= start_pos;
        MS_SQ_LOAD:  cx <= ipos_r;
        default:     cx <= np;
      endcase
    end
    if (cmd.latch) begin
      pos_r <= rd_pos;
      vel_r <= rd_vel;
      pbp_r <= rd_pbp;
      pbc_r <= rd_pbc;
    end
    if (cmd.acc_init) begin
      acc <= p_sh16[39:0];
    end else if (cmd.acc_add) begin
      acc <= acc + p_sh12[39:0];
    end
    if (cmd.vel_upd) begin
      nv <= sat32({{28{acc[39]}}, acc});
    end
    if (cmd.pos_upd) begin
      np <= sat32({{35{pos_sum[32]}}, pos_sum});
    end
    // Cost x*x - 3x + 1 in Q16.16: offset sum first, then floor shift and saturation.
    if (cmd.cost_a) begin
      csum <= prod_e - ((cx_e <<< 17) + (cx_e <<< 16)) + (68'sd1 <<< 32);
    end
    if (cmd.cost_b) begin
      cres <= sat32(csum_sh);
    end
    if (cmd.pb_upd && better) begin
      pbp_r <= np;
      pbc_r <= cres;
    end
  end

  // Global best, step count and run flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      gb_pos   <= RESET_START;
      gb_cost  <= RESET_START_COST;
      step_cnt <= 8'd0;
      run_fin  <= 1'b0;
      run_conv <= 1'b0;
    end else begin
      if (cmd.restart) begin
        gb_pos   <= start_pos;
        gb_cost  <= cres;
        step_cnt <= 8'd0;
        run_fin  <= 1'b0;
        run_conv <= 1'b0;
      end
      if (cmd.gb_upd && (pbc_r < gb_cost)) begin
        gb_pos  <= pbp_r;
        gb_cost <= pbc_r;
      end
      if (cmd.step_inc && (step_cnt != 8'hFF)) begin
        step_cnt <= step_cnt + 8'd1;
      end
      if (cmd.flags) begin
        if ((pspread_r < stop_thr) && (cspread_r < stop_thr)) begin
          run_conv <= 1'b1;
          run_fin  <= 1'b1;
        end
        if (step_cnt >= step_limit) begin
          run_fin <= 1'b1;
        end
      end
    end
  end

  // Particle memories.
  assign waddr   = cmd.load_wr ? IW'(idx_r) : cnt;
  assign we_main = (cmd.load_wr && idx_ok) || cmd.pb_upd;
  assign we_pb   = (cmd.load_wr && idx_ok) || (cmd.pb_upd && better);
  assign wpos    = cmd.load_wr ? ipos_r : np;
  assign wvel    = cmd.load_wr ? ivel_r : nv;
  assign wcost   = cres;

  psopt_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk(clk), .we(we_main), .waddr(waddr), .wdata(wpos), .raddr(cnt), .rdata(rd_pos)
  );
  psopt_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_vel_ram (
    .clk(clk), .we(we_main), .waddr(waddr), .wdata(wvel), .raddr(cnt), .rdata(rd_vel)
  );
  psopt_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_cost_ram (
    .clk(clk), .we(we_main), .waddr(waddr), .wdata(wcost), .raddr(cnt), .rdata(rd_cost)
  );
  psopt_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pbp_ram (
    .clk(clk), .we(we_pb), .waddr(waddr), .wdata(wpos), .raddr(cnt), .rdata(rd_pbp)
  );
  psopt_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pbc_ram (
    .clk(clk), .we(we_pb), .waddr(waddr), .wdata(wcost), .raddr(cnt), .rdata(rd_pbc)
  );

  // Min and max scan over positions and costs, one particle per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v <= 1'b0;
    end else begin
      scan_v <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    scan_first <= (cnt == '0);
    if (scan_v) begin
      if (scan_first) begin
        plo <= rd_pos;
        phi <= rd_pos;
        clo <= rd_cost;
        chi <= rd_cost;
      end else begin
        if ($signed(rd_pos) < plo) plo <= rd_pos;
        if ($signed(rd_pos) > phi) phi <= rd_pos;
        if ($signed(rd_cost) < clo) clo <= rd_cost;
        if ($signed(rd_cost) > chi) chi <= rd_cost;
      end
    end
  end

  // Spreads, saturated to 31 bits.
  assign pd = {phi[31], phi} - {plo[31], plo};
  assign cd = {chi[31], chi} - {clo[31], clo};

  always_ff @(posedge clk) begin
    if (cmd.spread_clr) begin
      pspread_r <= 31'd0;
      cspread_r <= 31'd0;
    end else if (cmd.spread) begin
      pspread_r <= (|pd[32:31]) ? '1 : pd[30:0];
      cspread_r <= (|cd[32:31]) ? '1 : cd[30:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      best_position   <= gb_pos;
      best_cost       <= gb_cost;
      position_spread <= pspread_r;
      cost_spread     <= cspread_r;
      steps_done      <= step_cnt;
      converged       <= run_conv;
      finished        <= run_fin || (step_cnt >= step_limit);
    end
  end

endmodule

@@ hw/rtl/psopt_ctrl.sv @@
// Controller state machine that sequences loads, swarm steps and result delivery.
module psopt_ctrl import psopt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_SQ      = 24'h000002,
    S_CA      = 24'h000004,
    S_CB      = 24'h000008,
    S_RESTART = 24'h000010,
    S_LOAD_WR = 24'h000020,
    S_DIV     = 24'h000040,
    S_RD      = 24'h000080,
    S_LATCH   = 24'h000100,
    S_MW      = 24'h000200,
    S_MG1     = 24'h000400,
    S_MP1     = 24'h000800,
    S_MG2     = 24'h001000,
    S_MP2     = 24'h002000,
    S_NV      = 24'h004000,
    S_VEL     = 24'h008000,
    S_POS     = 24'h010000,
    S_PB      = 24'h020000,
    S_GB      = 24'h040000,
    S_SCAN    = 24'h080000,
    S_DRAIN   = 24'h100000,
    S_SPREAD  = 24'h200000,
    S_FLAGS   = 24'h400000,
    S_RESULT  = 24'h800000
  } state_t;

  // What the shared cost sequence is working for.
  typedef enum logic [3:0] {
    PH_RESTART = 4'b0001,
    PH_LOAD    = 4'b0010,
    PH_STEP    = 4'b0100,
    PH_SCAN    = 4'b1000
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LOAD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Output register handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.in_step) begin
            cmd.cnt_clr = 1'b1;
            if (status.can_update) begin
              cmd.div_start = 1'b1;
              phase_next    = PH_STEP;
              state_next    = S_DIV;
            end else begin
              phase_next = PH_SCAN;
              state_next = S_SCAN;
            end
          end else begin
            phase_next = status.in_idx_zero ? PH_RESTART : PH_LOAD;
            state_next = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.sq     = 1'b1;
        if (phase == PH_RESTART) begin
          cmd.mul_sel = MS_SQ_START;
        end else if (phase == PH_LOAD) begin
          cmd.mul_sel = MS_SQ_LOAD;
        end else begin
          cmd.mul_sel = MS_SQ_NP;
        end
        state_next = S_CA;
      end
      S_CA: begin
        cmd.cost_a = 1'b1;
        state_next = S_CB;
      end
      S_CB: begin
        cmd.cost_b = 1'b1;
        if (phase == PH_RESTART) begin
          state_next = S_RESTART;
        end else if (phase == PH_LOAD) begin
          state_next = S_LOAD_WR;
        end else begin
          state_next = S_PB;
        end
      end
      S_RESTART: begin
        cmd.restart = 1'b1;
        phase_next  = PH_LOAD;
        state_next  = S_SQ;
      end
      S_LOAD_WR: begin
        cmd.load_wr    = 1'b1;
        cmd.spread_clr = 1'b1;
        state_next     = S_RESULT;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch  = 1'b1;
        state_next = S_MW;
      end
      S_MW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_W_VEL;
        state_next  = S_MG1;
      end
      S_MG1: begin
        cmd.acc_init = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_CR1;
        state_next   = S_MP1;
      end
      S_MP1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_G_PB;
        state_next  = S_MG2;
      end
      S_MG2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_CR2;
        state_next  = S_MP2;
      end
      S_MP2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_G_GB;
        state_next  = S_NV;
      end
      S_NV: begin
        cmd.acc_add = 1'b1;
        state_next  = S_VEL;
      end
      S_VEL: begin
        cmd.vel_upd = 1'b1;
        state_next  = S_POS;
      end
      S_POS: begin
        cmd.pos_upd = 1'b1;
        state_next  = S_SQ;
      end
      S_PB: begin
        cmd.pb_upd = 1'b1;
        state_next = S_GB;
      end
      S_GB: begin
        cmd.gb_upd = 1'b1;
        if (status.cnt_last) begin
          cmd.step_inc = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_SCAN;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.cnt_last) begin
          state_next = S_DRAIN;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_SPREAD;
      end
      S_SPREAD: begin
        cmd.spread = 1'b1;
        state_next = S_FLAGS;
      end
      S_FLAGS: begin
        cmd.flags  = (phase == PH_STEP);
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/psopt_chk.sv @@
// Port-level checker of the particle swarm optimizer and its binding to the top level.
module psopt_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // One item at a time: input is closed in the cycle after a transaction.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

  // A converged run is always reported as finished.
  a_conv_fin: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[134]) |-> m_axis_tdata[135])
    else $error("converged without finished");

endmodule

bind particle_swarm_optimizer_1d_unit psopt_chk u_chk (.*);
